// ===== hw/rtl/rmm_pkg.sv =====
// Shared types and constants for the running median multiset unit.
package rmm_pkg;

   // Default sizes handed to the top level parameters
   localparam int CAPACITY_DEF    = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   // Fixed port widths
   localparam int REQ_VALUE_W  = 32;
   localparam int RSP_MEDIAN_W = 32;
   localparam int RSP_COUNT_W  = 7;
   localparam int OPCODE_W     = 2;
   localparam int STATUS_W     = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_QUERY  = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // Broadcast control from the sequencer to every cell
   typedef struct packed {
      logic do_insert;
      logic do_erase;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/rmm_cell.sv =====
// One storage cell of the sorted chain: holds a value and shifts with its neighbors.
module rmm_cell
   import rmm_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int IDX_W       = 6,
   parameter int INDEX       = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cell_ctl_type                  ctl,
   input  logic signed [VALUE_WIDTH-1:0] key,
   input  logic [IDX_W-1:0]              mid_idx,
   // left neighbor (lower rank)
   input  logic signed [VALUE_WIDTH-1:0] left_val,
   input  logic                          left_vld,
   input  logic                          left_ins_at,
   // right neighbor (higher rank)
   input  logic signed [VALUE_WIDTH-1:0] right_val,
   input  logic                          right_vld,
   output logic signed [VALUE_WIDTH-1:0] val,
   output logic                          vld,
   output logic                          ins_at,
   output logic                          match,
   output logic [VALUE_WIDTH-1:0]        median_tap
);

   logic signed [VALUE_WIDTH-1:0] val_ff, val_in;
   logic                          vld_ff, vld_in;
   logic                          key_lt, val_lt, era_at;

   // Position flags; both are monotonic along the sorted chain
   assign key_lt = key < val_ff;
   assign val_lt = val_ff < key;
   assign ins_at = !vld_ff || key_lt;
   assign era_at = vld_ff && !val_lt;
   assign match  = vld_ff && (val_ff == key);

   // Lower median tap, OR-combined at the top level
   assign median_tap = (vld_ff && (mid_idx == IDX_W'(INDEX))) ? val_ff : '0;

   // Next content: shift right on insert, shift left on erase
   always_comb begin
      val_in = val_ff;
      vld_in = vld_ff;
      if (ctl.do_insert && ins_at) begin
         if (left_ins_at) begin
            val_in = left_val;
            vld_in = left_vld;
         end else begin
            val_in = key;
            vld_in = 1'b1;
         end
      end else if (ctl.do_erase && era_at) begin
         val_in = right_val;
         vld_in = right_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;
   assign vld = vld_ff;

endmodule

// ===== hw/rtl/running_median_multiset_unit.sv =====
// Top level of the running median multiset unit: decode, cell chain and result register.
//
// Keeps up to CAPACITY signed values sorted in a chain of cells. Each request
// (req_opcode, req_value) is transferred at a rising edge with start high and
// busy low: insert, erase one copy, or query the lower median.
// Every request gives exactly one result in the cycle after its transfer: rsp_valid pulses for
// one cycle with rsp_median, rsp_status and rsp_count. The receiver cannot
// stall; a result is taken in the cycle it is shown.
// Throughput is one request per cycle once busy is low: every cell compares the broadcast key
// with its own value and shifts with its neighbors in the same cycle, and the
// median is picked by the cell whose index matches (count-1)/2.
// Reset empties the store (all cells invalid, count zero) and holds busy high
// for its duration; busy falls in the first cycle after reset.
// Status: ok, query on empty store, insert dropped when full, erase of a
// value not present. Opcode 3 changes nothing and reports ok.
// Request values wider than VALUE_WIDTH wrap to VALUE_WIDTH bits; narrower ones are sign-extended.
module running_median_multiset_unit
   import rmm_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [OPCODE_W-1:0]            req_opcode,
   input  logic signed [REQ_VALUE_W-1:0]  req_value,
   output logic                           rsp_valid,
   output logic signed [RSP_MEDIAN_W-1:0] rsp_median,
   output logic [STATUS_W-1:0]            rsp_status,
   output logic [RSP_COUNT_W-1:0]         rsp_count
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                          busy_ff;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          rsp_valid_ff;
   logic signed [RSP_MEDIAN_W-1:0] rsp_median_ff, rsp_median_in;
   logic [STATUS_W-1:0]           rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]              rsp_count_ff;

   logic                          accept;
   logic signed [VALUE_WIDTH-1:0] key;
   cell_ctl_type                  ctl;
   logic [CNT_W-1:0]              count_m1;
   logic [IDX_W-1:0]              mid_idx;
   logic                          found;
   logic                          is_full, is_empty;
   logic [VALUE_WIDTH-1:0]        median_val;

   logic signed [VALUE_WIDTH-1:0] cell_val [CAPACITY];
   logic [CAPACITY-1:0]           cell_vld;
   logic [CAPACITY-1:0]           cell_ins_at;
   logic [CAPACITY-1:0]           cell_match;
   logic [VALUE_WIDTH-1:0]        cell_tap [CAPACITY];

   assign accept   = start && !busy_ff;
   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign found    = |cell_match;

   // Narrow or sign-extend the request value to the storage width
   generate
      if (VALUE_WIDTH >= REQ_VALUE_W) begin : g_key_ext
         assign key = VALUE_WIDTH'(req_value);
      end else begin : g_key_cut
         assign key = req_value[VALUE_WIDTH-1:0];
      end
   endgenerate

   // Lower median position (count-1)/2
   assign count_m1 = count_ff - CNT_W'(1);
   assign mid_idx  = IDX_W'(count_m1 >> 1);

   // Broadcast control to the chain
   always_comb begin
      ctl.do_insert = accept && (req_opcode == OP_INSERT) && !is_full;
      ctl.do_erase  = accept && (req_opcode == OP_ERASE) && found;
   end

   // Cell chain
   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic signed [VALUE_WIDTH-1:0] l_val, r_val;
         logic                          l_vld, l_ins, r_vld;
         if (i == 0) begin : g_first
            assign l_val = '0;
            assign l_vld = 1'b0;
            assign l_ins = 1'b0;
         end else begin : g_mid
            assign l_val = cell_val[i-1];
            assign l_vld = cell_vld[i-1];
            assign l_ins = cell_ins_at[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign r_val = '0;
            assign r_vld = 1'b0;
         end else begin : g_inner
            assign r_val = cell_val[i+1];
            assign r_vld = cell_vld[i+1];
         end
         rmm_cell #(
            .VALUE_WIDTH(VALUE_WIDTH),
            .IDX_W      (IDX_W),
            .INDEX      (i)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .key        (key),
            .mid_idx    (mid_idx),
            .left_val   (l_val),
            .left_vld   (l_vld),
            .left_ins_at(l_ins),
            .right_val  (r_val),
            .right_vld  (r_vld),
            .val        (cell_val[i]),
            .vld        (cell_vld[i]),
            .ins_at     (cell_ins_at[i]),
            .match      (cell_match[i]),
            .median_tap (cell_tap[i])
         );
      end
   endgenerate

   // Combine the median taps; at most one cell drives a nonzero tap
   always_comb begin
      median_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         median_val = median_val | cell_tap[i];
      end
   end

   // Result and count decode
   always_comb begin
      count_in      = count_ff;
      rsp_median_in = '0;
      rsp_status_in = ST_OK;
      unique case (req_opcode)
         OP_INSERT: begin
            if (is_full) begin
               rsp_status_in = ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_ERASE: begin
            if (found) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               rsp_status_in = ST_NOTFOUND;
            end
         end
         OP_QUERY: begin
            // sign-extend or wrap the stored value to the result width
            if (is_empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_median_in = RSP_MEDIAN_W'($signed(median_val));
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_median_ff <= rsp_median_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;
   assign rsp_status = rsp_status_ff;

   generate
      if (CNT_W >= RSP_COUNT_W) begin : g_cnt_cut
         assign rsp_count = rsp_count_ff[RSP_COUNT_W-1:0];
      end else begin : g_cnt_ext
         assign rsp_count = RSP_COUNT_W'(rsp_count_ff);
      end
   endgenerate

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("stored count exceeds capacity");

   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_vld) == int'(count_ff))
      else $error("valid cells disagree with stored count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_FULL) |-> rsp_count_ff == CNT_W'(CAPACITY))
      else $error("insert dropped while store not full");

   a_empty_median: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_EMPTY) |-> rsp_count_ff == '0)
      else $error("empty status with stored values");

endmodule

// ===== test/rmm_median_tracker.sv =====
// Result predictor and checker for the running median multiset unit.
module rmm_median_tracker
   import rmm_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [OPCODE_W-1:0]            req_opcode,
   input  logic signed [REQ_VALUE_W-1:0]  req_value,
   input  logic                           rsp_valid,
   input  logic signed [RSP_MEDIAN_W-1:0] rsp_median,
   input  logic [STATUS_W-1:0]            rsp_status,
   input  logic [RSP_COUNT_W-1:0]         rsp_count,
   output int                             mismatch_count,
   output int                             outstanding
);

   typedef struct {
      logic signed [RSP_MEDIAN_W-1:0] median;
      logic [STATUS_W-1:0]            status;
      logic [RSP_COUNT_W-1:0]         count;
   } median_result_type;

   // Shadow copy of the sorted store
   logic signed [REQ_VALUE_W-1:0] sorted_store [CAPACITY];
   int                            store_size = 0;
   median_result_type             pending_results [$];
   int                            fail_tally = 0;

   assign mismatch_count = fail_tally;
   assign outstanding    = pending_results.size();

   // Apply one request to the shadow store and return the result it should give
   function automatic median_result_type apply_request(
      input logic [OPCODE_W-1:0]           op,
      input logic signed [REQ_VALUE_W-1:0] key
   );
      median_result_type r;
      int                pos;
      r.median = '0;
      r.status = ST_OK;
      case (op)
         OP_INSERT: begin
            if (store_size >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               // shift larger entries up, then drop the key into the hole
               pos = store_size;
               while (pos > 0 && key < sorted_store[pos-1]) begin
                  sorted_store[pos] = sorted_store[pos-1];
                  pos--;
               end
               sorted_store[pos] = key;
               store_size++;
            end
         end
         OP_ERASE: begin
            pos = -1;
            for (int i = 0; i < store_size; i++) begin
               if (pos < 0 && sorted_store[i] == key) pos = i;
            end
            if (pos < 0) begin
               r.status = ST_NOTFOUND;
            end else begin
               for (int i = pos; i + 1 < store_size; i++) sorted_store[i] = sorted_store[i+1];
               store_size--;
            end
         end
         OP_QUERY: begin
            // lower median: 0-based position (n-1)/2
            if (store_size == 0) r.status = ST_EMPTY;
            else r.median = sorted_store[(store_size - 1) / 2];
         end
         default: ;
      endcase
      r.count = RSP_COUNT_W'(store_size);
      return r;
   endfunction

   // Compare each result with the oldest expectation, then predict any new transfer
   always @(posedge clock) begin
      median_result_type want;
      if (reset) begin
         store_size = 0;
         pending_results.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result: median %0d status %0d count %0d",
                        $time, rsp_median, rsp_status, rsp_count);
               fail_tally++;
            end else begin
               want = pending_results.pop_front();
               if (want.median !== rsp_median || want.status !== rsp_status ||
                   want.count !== rsp_count) begin
                  $display("%0t: mismatch: expected median %0d status %0d count %0d, got median %0d status %0d count %0d",
                           $time, want.median, want.status, want.count,
                           rsp_median, rsp_status, rsp_count);
                  fail_tally++;
               end
            end
         end
         if (start && !busy) pending_results.push_back(apply_request(req_opcode, req_value));
      end
   end

endmodule

// ===== test/running_median_multiset_unit_tb.sv =====
// Testbench top for the running median multiset unit: stimulus and verdict.
module running_median_multiset_unit_tb;
   import rmm_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET  = 1150;
   localparam int QUIET_TAIL   = 150;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 4;

   typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic [OPCODE_W-1:0]            req_opcode = '0;
   logic signed [REQ_VALUE_W-1:0]  req_value = '0;
   logic                           busy;
   logic                           rsp_valid;
   logic signed [RSP_MEDIAN_W-1:0] rsp_median;
   logic [STATUS_W-1:0]            rsp_status;
   logic [RSP_COUNT_W-1:0]         rsp_count;
   int                             mismatch_count;
   int                             outstanding;
   int                             cycle_count = 0;
   int                             items_sent = 0;
   bit                             quiet = 1'b0;
   // values believed to be in the store, used to aim erases at real entries
   logic signed [REQ_VALUE_W-1:0]  live_values [$];

   running_median_multiset_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_opcode (req_opcode),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_median (rsp_median),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   rmm_median_tracker #(.CAPACITY(CAPACITY_DEF)) u_tracker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_median     (rsp_median),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Present one request and hold it until the transfer, then maybe idle a while
   task automatic send_item(input logic [OPCODE_W-1:0] op,
                            input logic signed [REQ_VALUE_W-1:0] val);
      int gap;
      req_opcode <= op;
      req_value  <= val;
      start      <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Mix of small values (duplicates), corner values and full-range values
   function automatic logic signed [REQ_VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return REQ_VALUE_W'(int'($urandom_range(0, 12)) - 6);
         4: begin
            case ($urandom_range(0, 5))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h8000_0001;
               3: return 32'h7fff_fffe;
               4: return 32'hffff_ffff;
               default: return 32'h0000_0000;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   task automatic random_item(input phase_type ph);
      int                            roll;
      int                            ins_cut;
      int                            era_cut;
      int                            idx;
      logic signed [REQ_VALUE_W-1:0] v;
      roll = $urandom_range(0, 99);
      case (ph)
         PH_FILL: begin
            ins_cut = 85;
            era_cut = 90;
         end
         PH_DRAIN: begin
            ins_cut = 15;
            era_cut = 75;
         end
         default: begin
            ins_cut = 35;
            era_cut = 65;
         end
      endcase
      if (roll < ins_cut) begin
         v = pick_value();
         send_item(OP_INSERT, v);
         if (live_values.size() < CAPACITY_DEF) live_values.push_back(v);
      end else if (roll < era_cut) begin
         // mostly erase a stored value, sometimes one that is likely absent
         if (live_values.size() != 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, live_values.size() - 1);
            v   = live_values[idx];
            live_values.delete(idx);
         end else begin
            v = pick_value();
         end
         send_item(OP_ERASE, v);
      end else if (roll < 98) begin
         send_item(OP_QUERY, $urandom());
      end else begin
         send_item(OP_UNUSED, $urandom());
      end
   endtask

   initial begin
      phase_type ph;
      int        span;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty store, extremes, duplicates, absent erase, unused opcode
      send_item(OP_QUERY,  32'h0000_0000);
      send_item(OP_ERASE,  32'h0000_0005);
      send_item(OP_INSERT, 32'h8000_0000);
      send_item(OP_INSERT, 32'h7fff_ffff);
      send_item(OP_QUERY,  32'hffff_ffff);
      send_item(OP_INSERT, 32'h0000_0000);
      send_item(OP_INSERT, 32'h0000_0000);
      send_item(OP_INSERT, 32'hffff_ffff);
      send_item(OP_QUERY,  32'h1234_5678);
      send_item(OP_ERASE,  32'h0000_0000);
      send_item(OP_QUERY,  32'h0000_0000);
      send_item(OP_ERASE,  32'h0000_0000);
      send_item(OP_ERASE,  32'h0000_0000);
      send_item(OP_UNUSED, 32'ha5a5_5a5a);
      send_item(OP_ERASE,  32'h7fff_ffff);
      send_item(OP_ERASE,  32'h8000_0000);
      send_item(OP_INSERT, 32'h0000_0001);
      send_item(OP_QUERY,  32'h0000_0000);
      send_item(OP_ERASE,  32'hffff_ffff);
      send_item(OP_ERASE,  32'h0000_0001);
      send_item(OP_QUERY,  32'h5a5a_a5a5);
      send_item(OP_UNUSED, 32'h0000_0000);

      // Random phases: fill to capacity, drain, then a mix
      ph = PH_FILL;
      while (items_sent < ITEM_TARGET) begin
         span = (ph == PH_FILL) ? $urandom_range(110, 160) : $urandom_range(80, 160);
         repeat (span) begin
            if (items_sent >= ITEM_TARGET - QUIET_TAIL) quiet = 1'b1;
            random_item(ph);
         end
         case (ph)
            PH_FILL:  ph = PH_DRAIN;
            PH_DRAIN: ph = PH_MIXED;
            default:  ph = PH_FILL;
         endcase
      end
      start <= 1'b0;

      // Wait for every expected result, then let the bench settle before the verdict
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_TICKS) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== running_median_multiset_unit.f =====
hw/rtl/rmm_pkg.sv
hw/rtl/rmm_cell.sv
hw/rtl/running_median_multiset_unit.sv
test/rmm_median_tracker.sv
test/running_median_multiset_unit_tb.sv
